@@ rtl/core/histogram_mode_estimator_core_defines.svh @@
// Assertion macros shared by the histogram mode estimator RTL.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef HISTOGRAM_MODE_ESTIMATOR_CORE_DEFINES_SVH
`define HISTOGRAM_MODE_ESTIMATOR_CORE_DEFINES_SVH

// Checks a property on every rising clock edge outside reset.
`define HME_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition never holds outside reset.
`define HME_NEVER(lbl, cond, msg) \
  `HME_ASSERT(lbl, !(cond), msg)

`endif

@@ rtl/core/hme_pkg.sv @@
// Package for the histogram mode estimator: sizes, item codes, payload types
// and the command and status structs between controller and datapath. No dependencies.
package hme_pkg;

  // Histogram geometry.
  localparam int CHANNELS = 4;
  localparam int BINS     = 256;
  localparam int DEPTH    = CHANNELS * BINS;
  localparam int BIN_W    = $clog2(BINS);
  localparam int ADDR_W   = $clog2(DEPTH);

  // Saturation limit of one bin count.
  localparam logic [15:0] CNT_MAX = 16'hFFFF;

  // Reset value of the bin scale register (1.0 in Q16.16).
  localparam logic [31:0] SCALE_RESET = 32'h0001_0000;

  // Item kinds.
  localparam logic [1:0] KIND_COLLECT  = 2'd0;
  localparam logic [1:0] KIND_ESTIMATE = 2'd1;
  localparam logic [1:0] KIND_CLEAR    = 2'd2;

  // Input transaction payload.
  typedef struct packed {
    logic [1:0]         kind;
    logic [1:0]         channel;
    logic signed [31:0] sample_value;
  } hme_in_t;

  // Result transaction payload.
  typedef struct packed {
    logic signed [31:0] estimate_value;
    logic [7:0]         peak_bin;
  } hme_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic cnt_rd_col;
    logic wr_col;
    logic scan_init;
    logic cnt_rd_scan;
    logic lat_rd;
    logic out_load;
    logic clr_init;
    logic clr_wr;
  } hme_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] kind;
    logic       ch_ok;
    logic       scan_last;
    logic       clr_last;
    logic       out_free;
  } hme_status_t;

endpackage

@@ rtl/core/hme_ctrl.sv @@
// Controller state machine of the histogram mode estimator.
// Depends on hme_pkg and histogram_mode_estimator_core_defines.svh.
`include "histogram_mode_estimator_core_defines.svh"

module hme_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  hme_pkg::hme_status_t status,
  output hme_pkg::hme_cmd_t    cmd
);

  typedef enum logic [8:0] {
    S_CLR   = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_DEC   = 9'b000000100,
    S_RD    = 9'b000001000,
    S_WR    = 9'b000010000,
    S_SCAN  = 9'b000100000,
    S_DRAIN = 9'b001000000,
    S_LRD   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // The block takes a new transaction only while idle.
  assign in_stall = (state_r != S_IDLE);

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (status.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        cmd.capture = in_valid;
        if (in_valid) begin
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        state_nxt = S_IDLE;
        case (status.kind)
          hme_pkg::KIND_COLLECT: begin
            if (status.ch_ok) begin
              state_nxt = S_RD;
            end
          end
          hme_pkg::KIND_ESTIMATE: begin
            if (status.ch_ok) begin
              cmd.scan_init = 1'b1;
              state_nxt     = S_SCAN;
            end
          end
          hme_pkg::KIND_CLEAR: begin
            cmd.clr_init = 1'b1;
            state_nxt    = S_CLR;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_RD: begin
        cmd.cnt_rd_col = 1'b1;
        state_nxt      = S_WR;
      end
      S_WR: begin
        cmd.wr_col = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_SCAN: begin
        cmd.cnt_rd_scan = 1'b1;
        if (status.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_LRD;
      end
      S_LRD: begin
        cmd.lat_rd = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register; reset starts the clearing sweep.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  `HME_ASSERT(a_accept_decodes, (in_valid && !in_stall) |=> (state_r == S_DEC), "accepted transaction not decoded")
  `HME_ASSERT(a_clear_ends, (state_r == S_CLR && status.clr_last) |=> (state_r == S_IDLE), "clear sweep did not end")
  `HME_ASSERT(a_scan_holds, (state_r == S_SCAN && !status.scan_last) |=> (state_r == S_SCAN), "scan left early")

endmodule

@@ rtl/core/hme_datapath.sv @@
// Datapath of the histogram mode estimator: scale register, bin mapping,
// count and latest-value memories, peak scan and result register. Depends on hme_pkg.
`include "histogram_mode_estimator_core_defines.svh"

module hme_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  hme_pkg::hme_cmd_t    cmd,
  output hme_pkg::hme_status_t status,
  input  logic                 cfg_wr_en,
  input  logic [31:0]          cfg_wr_data,
  input  hme_pkg::hme_in_t     in_data,
  input  logic                 out_stall,
  output logic                 out_valid,
  output hme_pkg::hme_out_t    out_data
);

  localparam int BINS   = hme_pkg::BINS;
  localparam int DEPTH  = hme_pkg::DEPTH;
  localparam int BIN_W  = hme_pkg::BIN_W;
  localparam int BIN_W1 = BIN_W + 1;
  localparam int ADDR_W = hme_pkg::ADDR_W;

  logic [15:0] cnt_mem [DEPTH];
  logic [31:0] lat_mem [DEPTH];

  hme_pkg::hme_in_t  item_r;
  hme_pkg::hme_out_t out_data_r;
  logic [31:0]       scale_r;
  logic [63:0]       prod_r;
  logic [ADDR_W-1:0] col_addr_r;
  logic [ADDR_W-1:0] clr_addr_r;
  logic [BIN_W-1:0]  scan_idx_r;
  logic [BIN_W-1:0]  cmp_idx_r;
  logic [BIN_W-1:0]  best_r;
  logic [15:0]       best_cnt_r;
  logic              cmp_v_r;
  logic [15:0]       cnt_rd_r;
  logic [31:0]       lat_rd_r;
  logic              out_valid_r;

  logic [31:0]       mag;
  logic [31:0]       idx_hi;
  logic [BIN_W-1:0]  clamped;
  logic [BIN_W-1:0]  col_bin;
  logic [ADDR_W-1:0] base;
  logic [ADDR_W-1:0] col_addr;
  logic [ADDR_W-1:0] cnt_rd_addr;
  logic [15:0]       cnt_inc;
  logic [15:0]       peak_wide;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= hme_pkg::SCALE_RESET;
    end else if (cfg_wr_en) begin
      scale_r <= cfg_wr_data;
    end
  end

  // Captured item and the registered magnitude product.
  assign mag = item_r.sample_value[31] ? (32'd0 - 32'(item_r.sample_value))
                                       : 32'(item_r.sample_value);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_data;
    end
    prod_r <= 64'(mag) * 64'(scale_r);
  end

  // Bin mapping: clamp the integer part, then fold negative samples from the top.
  assign idx_hi  = prod_r[63:32];
  assign clamped = (idx_hi > 32'(BINS - 1)) ? BIN_W'(BINS - 1) : idx_hi[BIN_W-1:0];

  always_comb begin
    if (!item_r.sample_value[31]) begin
      col_bin = clamped;
    end else if (clamped == '0) begin
      col_bin = BIN_W'(BINS - 1);
    end else begin
      col_bin = BIN_W'(BIN_W1'(BINS) - {1'b0, clamped});
    end
  end

  assign base     = ADDR_W'(32'(item_r.channel) * BINS);
  assign col_addr = base + ADDR_W'(col_bin);

  // Count memory read port serves both the collect update and the peak scan.
  assign cnt_rd_addr = cmd.cnt_rd_scan ? (base + ADDR_W'(scan_idx_r)) : col_addr;
  assign cnt_inc     = (cnt_rd_r == hme_pkg::CNT_MAX) ? cnt_rd_r : (cnt_rd_r + 16'd1);

  always_ff @(posedge clk) begin
    if (cmd.cnt_rd_col || cmd.cnt_rd_scan) begin
      cnt_rd_r <= cnt_mem[cnt_rd_addr];
    end
    if (cmd.clr_wr) begin
      cnt_mem[clr_addr_r] <= '0;
    end else if (cmd.wr_col) begin
      cnt_mem[col_addr_r] <= cnt_inc;
    end
  end

  // Latest-value memory.
  always_ff @(posedge clk) begin
    if (cmd.lat_rd) begin
      lat_rd_r <= lat_mem[base + ADDR_W'(best_r)];
    end
    if (cmd.clr_wr) begin
      lat_mem[clr_addr_r] <= '0;
    end else if (cmd.wr_col) begin
      lat_mem[col_addr_r] <= 32'(item_r.sample_value);
    end
  end

  // Collect address is held for the write-back cycle.
  always_ff @(posedge clk) begin
    if (cmd.cnt_rd_col) begin
      col_addr_r <= col_addr;
    end
  end

  // Clearing sweep address.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr_init) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_addr_r <= clr_addr_r + ADDR_W'(1);
    end
  end

  // Peak scan: one read per cycle, each compared in the next cycle; ties keep the lower bin.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_v_r <= 1'b0;
    end else begin
      cmp_v_r <= cmd.cnt_rd_scan;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r <= scan_idx_r;
    if (cmd.scan_init) begin
      scan_idx_r <= '0;
      best_r     <= '0;
      best_cnt_r <= '0;
    end else begin
      if (cmd.cnt_rd_scan) begin
        scan_idx_r <= scan_idx_r + BIN_W'(1);
      end
      if (cmp_v_r && (cnt_rd_r > best_cnt_r)) begin
        best_cnt_r <= cnt_rd_r;
        best_r     <= cmp_idx_r;
      end
    end
  end

  // Result register.
  assign peak_wide = 16'(best_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r.estimate_value <= $signed(lat_rd_r);
      out_data_r.peak_bin       <= peak_wide[7:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Status to the controller.
  assign status.kind      = item_r.kind;
  assign status.ch_ok     = (32'(item_r.channel) < hme_pkg::CHANNELS);
  assign status.scan_last = (scan_idx_r == BIN_W'(BINS - 1));
  assign status.clr_last  = (clr_addr_r == ADDR_W'(DEPTH - 1));
  assign status.out_free  = !out_valid_r || !out_stall;

  `HME_NEVER(a_no_write_clash, cmd.wr_col && cmd.clr_wr, "collect write during clear sweep")
  `HME_ASSERT(a_cmp_follows_read, cmp_v_r |-> $past(cmd.cnt_rd_scan), "compare without scan read")
  `HME_ASSERT(a_load_when_free, cmd.out_load |-> (!out_valid_r || !out_stall), "result overwritten")

endmodule

@@ rtl/core/histogram_mode_estimator_core.sv @@
// Top level of the histogram mode estimator: controller plus datapath.
// Depends on hme_pkg, hme_ctrl and hme_datapath.
//
// Usage:
//   Input channel in_valid/in_stall/in_data carries one item per transaction:
//   collect (channel, Q16.16 sample), estimate (channel) or clear.
//   Output channel out_valid/out_stall/out_data returns one result per in-range
//   estimate: the latest value of the first most-counted bin and its index.
//   cfg_wr_en/cfg_wr_data write the Q16.16 bin scale; write only while idle.
// Sequence, with the controller handling one item at a time:
//   collect: decode and multiply, count read, then write-back.
//   estimate: the result is loaded after a scan of the count memory that reads
//   one bin per cycle.
//   clear: one word of each memory written per cycle, over every address.
//   Collect/estimate with a channel out of range, and kind 3, end after decode.
// Reset: a clearing sweep zeroes both memories; in_stall stays high until it
//   ends. The scale resets to 1.0.
// Stall: a result waits in the output register while out_stall is high; the
//   block keeps accepting collect and clear items meanwhile, and a following
//   estimate waits at its last step until the register frees.

module histogram_mode_estimator_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  hme_pkg::hme_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output hme_pkg::hme_out_t out_data,
  input  logic              cfg_wr_en,
  input  logic [31:0]       cfg_wr_data
);

  hme_pkg::hme_cmd_t    cmd;
  hme_pkg::hme_status_t status;

  // Sequencing of each item.
  hme_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Storage, arithmetic and result register.
  hme_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (in_data),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_data    (out_data)
  );

endmodule
